FILE: rtl/core/wlrs_pkg.sv
// wlrs_pkg: shared types and constants for the wear-leveled record store
// used by wlrs_div and wear_leveled_record_store; no dependencies
`timescale 1ns / 1ps

package wlrs_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int BASE_W      = 10;
	localparam int EXT_W       = ((ADDR_W > BASE_W) ? ADDR_W : BASE_W) + 3;
	localparam int CNT_W       = 8;
	localparam int DIV_STEPS_W = $clog2(CNT_W + 1);

	localparam logic       REQ_READ  = 1'b0;
	localparam logic       REQ_WRITE = 1'b1;
	localparam logic [1:0] SIZE_1B   = 2'd0;
	localparam logic [1:0] SIZE_2B   = 2'd1;
	localparam logic [1:0] SIZE_4B   = 2'd2;
	localparam logic [1:0] SIZE_MAX  = SIZE_4B;

	typedef struct packed {
		logic              req_type;
		logic [BASE_W-1:0] base_addr;
		logic [CNT_W-1:0]  slot_count;
		logic [1:0]        item_size;
		logic [31:0]       write_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        error;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_MOD,
		ST_ADDR,
		ST_CNT_RD,
		ST_WR_DATA,
		ST_WR_CNT,
		ST_RD_DATA,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/wlrs_div.sv
// wlrs_div: iterative restoring divider that yields the remainder, one bit per cycle
// depends on wlrs_pkg
`timescale 1ns / 1ps

module wlrs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wlrs_pkg::CNT_W-1:0] dividend,
	input  logic [wlrs_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [wlrs_pkg::CNT_W-1:0] rem
);

	logic [wlrs_pkg::CNT_W-1:0]       dvd_q;
	logic [wlrs_pkg::CNT_W-1:0]       dsr_q;
	logic [wlrs_pkg::CNT_W-1:0]       rem_q;
	logic [wlrs_pkg::DIV_STEPS_W-1:0] cnt_q;
	logic                             done_q;
	logic [wlrs_pkg::CNT_W:0]         trial;
	logic [wlrs_pkg::CNT_W:0]         diff;
	logic [wlrs_pkg::CNT_W-1:0]       rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[wlrs_pkg::CNT_W-1]};
		diff   = trial - {1'b0, dsr_q};
		rem_nx = (trial >= {1'b0, dsr_q}) ? diff[wlrs_pkg::CNT_W-1:0]
			: trial[wlrs_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == wlrs_pkg::DIV_STEPS_W'(1));
			if (start) begin
				cnt_q <= wlrs_pkg::DIV_STEPS_W'(wlrs_pkg::CNT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - wlrs_pkg::DIV_STEPS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dsr_q))
		else $error("remainder not below divisor");

	a_count_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (cnt_q == wlrs_pkg::DIV_STEPS_W'(wlrs_pkg::CNT_W)))
		else $error("step count not loaded on start");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

endmodule

FILE: rtl/core/wear_leveled_record_store.sv
// wear_leveled_record_store: wear-leveled record reads and writes over a byte store
// depends on wlrs_pkg and wlrs_div
`timescale 1ns / 1ps

// Requests enter on req/req_valid/req_stall, one response per request leaves
// on rsp/rsp_valid/rsp_stall. A request is taken when valid is high and stall
// is low. One request is worked at a time; a finished response waits in an
// output register, so the next request is taken while it is still stalled.
// A request walks its N counter bytes through the single-port store (one read
// a cycle), takes the sum modulo N in the wlrs_div remainder unit, then moves
// the slot bytes (1, 2 or 4) one per cycle. A request with zero slot count,
// a bad size code or counters beyond the store goes straight to ST_DONE; a
// slot beyond the store is caught after the remainder step. Such requests
// report error and change nothing. The next request is taken in the cycle
// after a response is loaded. After reset the store is swept to zero, one
// byte a cycle, with req_stall high. A response held by rsp_stall blocks
// only the next response, not the next request's work.

module wear_leveled_record_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  wlrs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output wlrs_pkg::rsp_t rsp
);

	wlrs_pkg::state_t state_q;
	wlrs_pkg::state_t state_d;
	wlrs_pkg::req_t   req_q;
	wlrs_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	logic             rsp_load;

	logic [7:0]                   mem [wlrs_pkg::STORE_BYTES];
	logic [7:0]                   rdata_q;
	logic                         mem_we;
	logic                         mem_re;
	logic [wlrs_pkg::ADDR_W-1:0]  mem_waddr;
	logic [wlrs_pkg::ADDR_W-1:0]  mem_raddr;
	logic [7:0]                   mem_wdata;

	logic [wlrs_pkg::ADDR_W-1:0]  clr_q;
	logic [wlrs_pkg::CNT_W-1:0]   iss_q;
	logic                         rd_s1;
	logic [1:0]                   rd_idx_s1;
	logic [wlrs_pkg::CNT_W-1:0]   sum_q;
	logic [wlrs_pkg::CNT_W-1:0]   slot_q;
	logic [wlrs_pkg::EXT_W-1:0]   daddr_q;
	logic [31:0]                  value_q;
	logic                         err_q;

	logic                         div_start;
	logic                         div_done;
	logic [wlrs_pkg::CNT_W-1:0]   div_rem;

	logic                         in_bad;
	logic [wlrs_pkg::EXT_W-1:0]   in_end;
	logic [2:0]                   nbytes;
	logic [wlrs_pkg::CNT_W-1:0]   slot_inc;
	logic [wlrs_pkg::CNT_W-1:0]   slot_nx;
	logic [wlrs_pkg::EXT_W-1:0]   rec_end;
	logic [wlrs_pkg::EXT_W-1:0]   daddr_nx;
	logic                         range_bad;
	logic [wlrs_pkg::EXT_W-1:0]   cnt_addr;
	logic [wlrs_pkg::EXT_W-1:0]   sum_addr;
	logic [wlrs_pkg::EXT_W-1:0]   byte_addr;

	wlrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (req_q.slot_count),
		.done     (div_done),
		.rem      (div_rem)
	);

	// request checks and address arithmetic
	always_comb begin
		in_end = wlrs_pkg::EXT_W'(req.base_addr) + wlrs_pkg::EXT_W'(req.slot_count);
		in_bad = (req.slot_count == '0) || (req.item_size > wlrs_pkg::SIZE_MAX)
			|| (in_end > wlrs_pkg::EXT_W'(wlrs_pkg::STORE_BYTES));

		nbytes   = 3'd1 << req_q.item_size;
		slot_inc = div_rem + wlrs_pkg::CNT_W'(1);
		if (req_q.req_type == wlrs_pkg::REQ_WRITE) begin
			slot_nx = (slot_inc == req_q.slot_count) ? '0 : slot_inc;
		end else begin
			slot_nx = div_rem;
		end
		rec_end   = wlrs_pkg::EXT_W'(req_q.base_addr) + wlrs_pkg::EXT_W'(req_q.slot_count);
		daddr_nx  = rec_end + (wlrs_pkg::EXT_W'(slot_nx) << req_q.item_size);
		range_bad = (daddr_nx + wlrs_pkg::EXT_W'(nbytes))
			> wlrs_pkg::EXT_W'(wlrs_pkg::STORE_BYTES);

		sum_addr  = wlrs_pkg::EXT_W'(req_q.base_addr) + wlrs_pkg::EXT_W'(iss_q);
		cnt_addr  = wlrs_pkg::EXT_W'(req_q.base_addr) + wlrs_pkg::EXT_W'(slot_q);
		byte_addr = daddr_q + wlrs_pkg::EXT_W'(iss_q);
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cnt_addr[wlrs_pkg::ADDR_W-1:0];
		mem_raddr = sum_addr[wlrs_pkg::ADDR_W-1:0];
		mem_wdata = '0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			wlrs_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == wlrs_pkg::ADDR_W'(wlrs_pkg::STORE_BYTES - 1)) begin
					state_d = wlrs_pkg::ST_IDLE;
				end
			end
			wlrs_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = in_bad ? wlrs_pkg::ST_DONE : wlrs_pkg::ST_SUM;
				end
			end
			wlrs_pkg::ST_SUM: begin
				mem_re = (iss_q < req_q.slot_count);
				if (iss_q == req_q.slot_count && !rd_s1) begin
					div_start = 1'b1;
					state_d   = wlrs_pkg::ST_MOD;
				end
			end
			wlrs_pkg::ST_MOD: begin
				if (div_done) begin
					state_d = wlrs_pkg::ST_ADDR;
				end
			end
			wlrs_pkg::ST_ADDR: begin
				if (range_bad) begin
					state_d = wlrs_pkg::ST_DONE;
				end else if (req_q.req_type == wlrs_pkg::REQ_WRITE) begin
					state_d = wlrs_pkg::ST_CNT_RD;
				end else begin
					state_d = wlrs_pkg::ST_RD_DATA;
				end
			end
			wlrs_pkg::ST_CNT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_addr[wlrs_pkg::ADDR_W-1:0];
				state_d   = wlrs_pkg::ST_WR_DATA;
			end
			wlrs_pkg::ST_WR_DATA: begin
				mem_we    = 1'b1;
				mem_waddr = byte_addr[wlrs_pkg::ADDR_W-1:0];
				mem_wdata = req_q.write_value[iss_q[1:0]*8 +: 8];
				if (iss_q == wlrs_pkg::CNT_W'(nbytes - 3'd1)) begin
					state_d = wlrs_pkg::ST_WR_CNT;
				end
			end
			wlrs_pkg::ST_WR_CNT: begin
				mem_we    = 1'b1;
				mem_wdata = (rdata_q == req_q.slot_count - wlrs_pkg::CNT_W'(1)) ? '0
					: rdata_q + 8'd1;
				state_d   = wlrs_pkg::ST_DONE;
			end
			wlrs_pkg::ST_RD_DATA: begin
				mem_re    = (iss_q < wlrs_pkg::CNT_W'(nbytes));
				mem_raddr = byte_addr[wlrs_pkg::ADDR_W-1:0];
				if (iss_q == wlrs_pkg::CNT_W'(nbytes) && !rd_s1) begin
					state_d = wlrs_pkg::ST_DONE;
				end
			end
			wlrs_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = wlrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wlrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wlrs_pkg::ST_CLEAR;
			clr_q       <= '0;
			iss_q       <= '0;
			rd_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= mem_re;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				wlrs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + wlrs_pkg::ADDR_W'(1);
				end
				wlrs_pkg::ST_IDLE, wlrs_pkg::ST_ADDR: begin
					iss_q <= '0;
				end
				wlrs_pkg::ST_SUM, wlrs_pkg::ST_RD_DATA, wlrs_pkg::ST_WR_DATA: begin
					if (mem_re || mem_we) begin
						iss_q <= iss_q + wlrs_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request payload and accumulators
	always_ff @(posedge clk) begin
		rd_idx_s1 <= iss_q[1:0];
		if (rsp_load) begin
			rsp_q <= '{read_value: value_q, error: err_q};
		end
		unique case (state_q)
			wlrs_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_q   <= req;
					sum_q   <= '0;
					value_q <= '0;
					err_q   <= in_bad;
				end
			end
			wlrs_pkg::ST_SUM: begin
				if (rd_s1) begin
					sum_q <= sum_q + rdata_q;
				end
			end
			wlrs_pkg::ST_ADDR: begin
				slot_q  <= slot_nx;
				daddr_q <= daddr_nx;
				err_q   <= range_bad;
			end
			wlrs_pkg::ST_RD_DATA: begin
				if (rd_s1) begin
					value_q[rd_idx_s1*8 +: 8] <= rdata_q;
				end
			end
			default: begin
			end
		endcase
	end

	// byte store, one access a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and written in the same cycle");

	a_counter_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlrs_pkg::ST_WR_CNT) |-> (slot_q < req_q.slot_count))
		else $error("counter update outside the record");

	a_rsp_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlrs_pkg::ST_DONE && rsp_valid_q && rsp_stall)
		|=> (state_q == wlrs_pkg::ST_DONE && $stable(rsp_q)))
		else $error("pending response overwritten");

	a_no_rsp_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wlrs_pkg::ST_CLEAR) |-> !rsp_valid_q)
		else $error("response during clearing pass");

endmodule
